FILE: sv/ssd_pkg.sv
// Shared types, constants and the CRC byte update for the section stream deframer.
package ssd_pkg;

	localparam logic [15:0] CRC_POLY  = 16'h1f45;
	localparam logic [15:0] CRC_START = 16'h8320;
	localparam logic [31:0] END_TYPE  = 32'hffff_ffff;

	localparam logic [1:0] EV_SECTION = 2'd0;
	localparam logic [1:0] EV_PAYLOAD = 2'd1;
	localparam logic [1:0] EV_END     = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] sect_type;
		logic [30:0]        sect_len;
		logic [31:0]        pay_off;
		logic [7:0]         pay_byte;
		logic               pad;
		logic               match;
		logic [15:0]        crc;
	} ssd_event_t;

	// Shift-left CRC over one byte, most significant bit first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/ssd_in_reg.sv
// Input register stage holding one stream word.
module ssd_in_reg import ssd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       out_free,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic advance;

	assign advance  = valid_s1 & out_free;
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

FILE: sv/ssd_parser.sv
// Framing state machine, CRC accumulation and event generation.
module ssd_parser import ssd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_s1,
	output logic       ev_valid,
	output ssd_event_t ev
);

	typedef enum logic [1:0] {
		PH_CHECK_HDR,
		PH_SECT_HDR,
		PH_PAYLOAD
	} phase_t;

	phase_t      phase_q, phase_nx;
	logic [2:0]  cnt_q, cnt_nx;
	logic [63:0] shift_q, shift_nx, shift_in;
	logic [15:0] crc_q, crc_nx;
	logic [31:0] decl_q, decl_nx;
	logic [31:0] left_q, left_nx;
	logic        ovr_q, ovr_nx;
	logic [31:0] type_q, type_nx;
	logic [30:0] len_q, len_nx;
	logic [31:0] total_q, total_nx;
	logic [31:0] done_q, done_nx;
	logic [31:0] poff_q, poff_nx;
	logic [31:0] off_q, off_nx;
	logic [31:0] w0, w1;
	logic [30:0] new_len;

	always_comb begin
		phase_nx = phase_q;
		cnt_nx   = cnt_q;
		shift_nx = shift_q;
		crc_nx   = crc_q;
		decl_nx  = decl_q;
		left_nx  = left_q;
		ovr_nx   = ovr_q;
		type_nx  = type_q;
		len_nx   = len_q;
		total_nx = total_q;
		done_nx  = done_q;
		poff_nx  = poff_q;
		off_nx   = off_q;
		ev_valid = 1'b0;
		ev       = '0;
		shift_in = {byte_s1, shift_q[63:8]};
		w0       = shift_in[31:0];
		w1       = shift_in[63:32];
		new_len  = w1[31] ? 31'd0 : w1[30:0];

		if (take) begin
			off_nx = off_q + 32'd1;
			// Every word after the check header counts towards the group.
			if (phase_q != PH_CHECK_HDR) begin
				if (left_q != 32'd0) begin
					left_nx = left_q - 32'd1;
					crc_nx  = crc16_byte(crc_q, byte_s1);
				end else begin
					ovr_nx = 1'b1;
				end
			end

			if (phase_q == PH_PAYLOAD) begin
				ev_valid     = 1'b1;
				ev.kind      = EV_PAYLOAD;
				ev.sect_type = type_q;
				ev.sect_len  = len_q;
				ev.pay_off   = poff_q;
				ev.pay_byte  = byte_s1;
				ev.pad       = (done_q >= {1'b0, len_q});
				done_nx      = done_q + 32'd1;
				if (done_nx == total_q) begin
					phase_nx = PH_SECT_HDR;
				end
			end else begin
				shift_nx = shift_in;
				cnt_nx   = cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					shift_nx = '0;
					if (phase_q == PH_CHECK_HDR) begin
						left_nx  = w0;
						decl_nx  = w1;
						crc_nx   = CRC_START;
						ovr_nx   = 1'b0;
						phase_nx = PH_SECT_HDR;
					end else if (w0 == END_TYPE) begin
						ev_valid     = 1'b1;
						ev.kind      = EV_END;
						ev.sect_type = END_TYPE;
						ev.match     = !ovr_nx && (left_nx == 32'd0) &&
						               ({16'h0000, crc_nx} == decl_q);
						ev.crc       = crc_nx;
						phase_nx     = PH_CHECK_HDR;
					end else begin
						type_nx      = w0;
						len_nx       = new_len;
						total_nx     = ({1'b0, new_len} + 32'd3) & ~32'd3;
						done_nx      = '0;
						poff_nx      = off_nx;
						ev_valid     = 1'b1;
						ev.kind      = EV_SECTION;
						ev.sect_type = w0;
						ev.sect_len  = new_len;
						ev.pay_off   = off_nx;
						phase_nx     = (total_nx != 32'd0) ? PH_PAYLOAD : PH_SECT_HDR;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CHECK_HDR;
			cnt_q   <= '0;
			shift_q <= '0;
			crc_q   <= CRC_START;
			decl_q  <= '0;
			left_q  <= '0;
			ovr_q   <= 1'b0;
			type_q  <= '0;
			len_q   <= '0;
			total_q <= '0;
			done_q  <= '0;
			poff_q  <= '0;
			off_q   <= '0;
		end else begin
			phase_q <= phase_nx;
			cnt_q   <= cnt_nx;
			shift_q <= shift_nx;
			crc_q   <= crc_nx;
			decl_q  <= decl_nx;
			left_q  <= left_nx;
			ovr_q   <= ovr_nx;
			type_q  <= type_nx;
			len_q   <= len_nx;
			total_q <= total_nx;
			done_q  <= done_nx;
			poff_q  <= poff_nx;
			off_q   <= off_nx;
		end
	end

endmodule

FILE: sv/ssd_out_reg.sv
// Result register driving the output channel.
module ssd_out_reg import ssd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ev_valid,
	input  ssd_event_t ev,
	output logic       out_free,
	output logic       out_valid,
	input  logic       out_stall,
	output ssd_event_t ev_q
);

	assign out_free = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && ev_valid) begin
			ev_q <= ev;
		end
	end

endmodule

FILE: sv/section_stream_deframer_crc16_top.sv
// A word accepted into the input register passes the framing logic into the result register, if it gives a result.
// One word per cycle while the output is not stalled; the input register and the result register are
// the only stages, with the framing and CRC update between them.
// A stalled output holds one result and one further word waits in the input register.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser
// to expecting a check header with the CRC at its start value.
module section_stream_deframer_crc16_top import ssd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         event_kind,
	output logic signed [31:0] section_type,
	output logic [30:0]        section_length,
	output logic [31:0]        payload_offset,
	output logic [7:0]         payload_byte,
	output logic               is_padding,
	output logic               crc_match,
	output logic [15:0]        crc_value
);

	logic       out_free;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       ev_valid;
	ssd_event_t ev;
	ssd_event_t ev_q;

	ssd_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.out_free  (out_free),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	ssd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (valid_s1 & out_free),
		.byte_s1  (byte_s1),
		.ev_valid (ev_valid),
		.ev       (ev)
	);

	ssd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev        (ev),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ev_q      (ev_q)
	);

	assign event_kind     = ev_q.kind;
	assign section_type   = ev_q.sect_type;
	assign section_length = ev_q.sect_len;
	assign payload_offset = ev_q.pay_off;
	assign payload_byte   = ev_q.pay_byte;
	assign is_padding     = ev_q.pad;
	assign crc_match      = ev_q.match;
	assign crc_value      = ev_q.crc;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_end_type: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == EV_END) |-> (section_type == END_TYPE &&
		section_length == 31'd0 && payload_offset == 32'd0))
		else $error("group end carries section fields");

	a_payload_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind != EV_PAYLOAD) |-> (payload_byte == 8'd0 && !is_padding))
		else $error("payload fields set outside a payload word");

	a_check_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind != EV_END) |-> (!crc_match && crc_value == 16'd0))
		else $error("check fields set outside a group end");
`endif

endmodule
